// File: rtl/bd2_pkg.sv
// Shared constants and types of the 2x2 box-average downsampler.
package bd2_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int CFG_W       = 11;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 16;
    localparam int PAIR_W      = PIX_W + 1;
    localparam int SUM_W       = PIX_W + 2;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
    } t_dims;

endpackage

// File: rtl/bd2_cfg.sv
// Configuration registers, holding the clamped last column and last row.
module bd2_cfg
    import bd2_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_dims            o_dims
);

    logic [COL_W-1:0] r_col_last, n_col_last;
    logic [ROW_W-1:0] r_row_last, n_row_last;
    logic [CFG_W-1:0] data_m1;

    assign data_m1 = i_cfg_data - CFG_W'(1);

    always_comb begin
        n_col_last = r_col_last;
        n_row_last = r_row_last;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        n_col_last = '0;
                    end else if (i_cfg_data > CFG_W'(MAX_WIDTH)) begin
                        n_col_last = COL_W'(MAX_WIDTH - 1);
                    end else begin
                        n_col_last = data_m1[COL_W-1:0];
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        n_row_last = '0;
                    end else if (i_cfg_data > CFG_W'(MAX_HEIGHT)) begin
                        n_row_last = ROW_W'(MAX_HEIGHT - 1);
                    end else begin
                        n_row_last = data_m1[ROW_W-1:0];
                    end
                end
                default: begin
                    n_col_last = r_col_last;
                    n_row_last = r_row_last;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= COL_W'(MAX_WIDTH - 1);
            r_row_last <= ROW_W'(MAX_HEIGHT - 1);
        end else begin
            r_col_last <= n_col_last;
            r_row_last <= n_row_last;
        end
    end

    assign o_dims.col_last = r_col_last;
    assign o_dims.row_last = r_row_last;

endmodule

// File: rtl/box_downsample_2x2.sv
// Top level of the 2x2 box-average downsampler with its line store.
//
// Pixels enter in raster order on the input channel (i_valid/o_ready), one
// transaction per pixel. Each 2x2 block yields one result on the output
// channel (o_valid/i_ready) carrying its floor-rounded mean, a row end flag
// and a frame end flag. Blocks cut by an odd width or height average the
// two or one pixels present.
// Pixels of even rows add into horizontal pair sums kept in a 512-entry
// line store; odd rows read the stored sum above and complete the block.
// The store is read and written at the input transaction; the stored sum
// and the new pair pass through the middle stage registers, and the mean
// of the block is registered in the output register that drives the output.
// Throughput is one pixel per cycle while the receiver keeps up.
// When the receiver stalls, the output register and the middle stage fill
// and o_ready then drops until the held result is taken.
// Reset clears the counters, sets the image to 1024 by 1024 and empties the
// pipeline; the line store needs no clearing, since an odd row reads only
// entries that the even row above wrote.
// The user writes width and height through the configuration port only while idle; the block does not enforce it.
module box_downsample_2x2
    import bd2_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [PIX_W-1:0] i_pixel,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [PIX_W-1:0] o_average,
    output logic                    o_row_end,
    output logic                    o_frame_end
);

    t_dims dims;

    bd2_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_dims      (dims)
    );

    logic signed [PAIR_W-1:0] r_store [STORE_DEPTH];

    logic [COL_W-1:0]         r_col, n_col;
    logic [ROW_W-1:0]         r_row, n_row;
    logic signed [PAIR_W-1:0] r_pair, n_pair;

    logic                     r_s1_valid;
    logic                     r_s1_emit;
    logic                     r_s1_odd_row;
    logic                     r_s1_odd_col;
    logic                     r_s1_row_end;
    logic                     r_s1_frame_end;
    logic signed [PAIR_W-1:0] r_s1_pair;
    logic signed [PAIR_W-1:0] r_s1_above;

    logic                     r_out_valid;
    logic signed [PIX_W-1:0]  r_out_average;
    logic                     r_out_row_end;
    logic                     r_out_frame_end;

    logic                     in_fire;
    logic                     out_free;
    logic                     s1_move;
    logic                     last_col;
    logic                     last_row;
    logic                     odd_col;
    logic                     odd_row;
    logic                     pair_done;
    logic [SLOT_W-1:0]        slot;
    logic signed [SUM_W-1:0]  blk_sum;
    logic signed [SUM_W-1:0]  blk_mean;
    logic [1:0]               blk_shift;

    assign out_free = !r_out_valid || i_ready;
    assign s1_move  = r_s1_valid && (!r_s1_emit || out_free);
    assign o_ready  = !r_s1_valid || s1_move;
    assign in_fire  = i_valid && o_ready;

    assign last_col  = r_col >= dims.col_last;
    assign last_row  = r_row >= dims.row_last;
    assign odd_col   = r_col[0];
    assign odd_row   = r_row[0];
    assign pair_done = odd_col || last_col;
    assign slot      = r_col[COL_W-1:1];

    always_comb begin
        if (odd_col) begin
            n_pair = r_pair + PAIR_W'(i_pixel);
        end else begin
            n_pair = PAIR_W'(i_pixel);
        end
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (pair_done && !odd_row && !last_row) begin
                r_store[slot] <= n_pair;
            end
            r_s1_above     <= r_store[slot];
            r_s1_pair      <= n_pair;
            r_s1_odd_row   <= odd_row;
            r_s1_odd_col   <= odd_col;
            r_s1_row_end   <= last_col;
            r_s1_frame_end <= last_col && last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_pair     <= '0;
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_pair     <= n_pair;
                r_s1_valid <= 1'b1;
                r_s1_emit  <= pair_done && (odd_row || last_row);
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
                r_s1_emit  <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_s1_odd_row) begin
            blk_sum = SUM_W'(r_s1_pair) + SUM_W'(r_s1_above);
        end else begin
            blk_sum = SUM_W'(r_s1_pair);
        end
        blk_shift = {1'b0, r_s1_odd_row} + {1'b0, r_s1_odd_col};
        blk_mean  = blk_sum >>> blk_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move && r_s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_emit) begin
            r_out_average   <= blk_mean[PIX_W-1:0];
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_average   = r_out_average;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

endmodule

// File: tb/tb_box_downsample_2x2.sv
// Self-checking testbench for the 2x2 box-average downsampler with a scoreboard class.
`timescale 1ns / 1ps

module tb_box_downsample_2x2;
    import bd2_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_ITEMS   = 700;

    typedef struct packed {
        logic signed [PIX_W-1:0] average;
        logic                    row_end;
        logic                    frame_end;
    } t_block_mean;

    class box_mean_scoreboard;
        logic [CFG_W-1:0]         width_reg;
        logic [CFG_W-1:0]         height_reg;
        logic [COL_W-1:0]         col_idx;
        logic [ROW_W-1:0]         row_idx;
        logic signed [PAIR_W-1:0] pair_acc;
        logic signed [PAIR_W-1:0] line_store [STORE_DEPTH];
        bit                       slot_written [STORE_DEPTH];
        t_block_mean              expected_means [$];
        int                       errors;

        function new();
            width_reg  = CFG_W'(MAX_WIDTH);
            height_reg = CFG_W'(MAX_HEIGHT);
            col_idx    = '0;
            row_idx    = '0;
            pair_acc   = '0;
            errors     = 0;
            foreach (slot_written[s]) slot_written[s] = 1'b0;
        endfunction

        function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned max_dim);
            if (v == 0) return 1;
            return (v > max_dim) ? max_dim : v;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_IMAGE_WIDTH: width_reg = v;
                REG_IMAGE_HEIGHT: height_reg = v;
                default: ;
            endcase
        endfunction

        // An odd row reads the pair sums above it, so a wider row is only
        // allowed there if every slot it will read holds a stored value.
        function bit width_is_safe(logic [CFG_W-1:0] v);
            int unsigned last_slot;
            int s;
            last_slot = (clamp_dim(v, MAX_WIDTH) - 1) / 2;
            if (!row_idx[0]) return 1'b1;
            for (s = 0; s <= last_slot; s++) begin
                if (!slot_written[s]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function int unsigned pixels_left_in_frame();
            int unsigned w;
            int unsigned h;
            int unsigned in_row;
            int unsigned rows_after;
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            in_row = (col_idx >= w - 1) ? 1 : w - col_idx;
            rows_after = (row_idx >= h - 1) ? 0 : h - 1 - row_idx;
            return in_row + rows_after * w;
        endfunction

        function void note_pixel(logic signed [PIX_W-1:0] pix);
            int unsigned             w;
            int unsigned             h;
            bit                      last_col;
            bit                      last_row;
            bit                      odd_col;
            logic [SLOT_W-1:0]       slot;
            logic signed [SUM_W-1:0] above;
            logic signed [SUM_W-1:0] total;
            t_block_mean             res;
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            last_col = col_idx >= w - 1;
            last_row = row_idx >= h - 1;
            odd_col = col_idx[0];
            slot = col_idx[COL_W-1:1];
            if (odd_col) begin
                pair_acc = pair_acc + pix;
            end else begin
                pair_acc = pix;
            end
            if (odd_col || last_col) begin
                res.row_end = last_col;
                res.frame_end = last_col && last_row;
                if (row_idx[0]) begin
                    above = SUM_W'(line_store[slot]);
                    total = above + pair_acc;
                    total = total >>> (odd_col ? 2 : 1);
                    res.average = total[PIX_W-1:0];
                    expected_means.push_back(res);
                end else if (last_row) begin
                    total = SUM_W'(pair_acc);
                    total = total >>> (odd_col ? 1 : 0);
                    res.average = total[PIX_W-1:0];
                    expected_means.push_back(res);
                end else begin
                    line_store[slot] = pair_acc;
                    slot_written[slot] = 1'b1;
                end
            end
            if (last_col) begin
                col_idx = '0;
                row_idx = last_row ? '0 : row_idx + 1'b1;
            end else begin
                col_idx = col_idx + 1'b1;
            end
        endfunction

        function void check_result(t_block_mean got);
            t_block_mean want;
            if (expected_means.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual average %0d",
                         $time, got.average);
                errors++;
                return;
            end
            want = expected_means.pop_front();
            if (got.average !== want.average) begin
                $display("%0t: average expected %0d actual %0d",
                         $time, want.average, got.average);
                errors++;
            end
            if (got.row_end !== want.row_end) begin
                $display("%0t: row_end expected %0b actual %0b",
                         $time, want.row_end, got.row_end);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $display("%0t: frame_end expected %0b actual %0b",
                         $time, want.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [0:0]              i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [PIX_W-1:0] i_pixel;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [PIX_W-1:0] o_average;
    logic                    o_row_end;
    logic                    o_frame_end;

    box_mean_scoreboard sb = new();
    t_block_mean        observed;
    int                 burst_left = 0;
    int                 ready_mode = 0;
    int                 ready_hold = 0;
    int                 stall_cycles = 0;

    box_downsample_2x2 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_average   (o_average),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(20, 100);
        end
        ready_hold--;
        case (ready_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 1) == 1);
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= (ready_hold % 17 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            observed.average = o_average;
            observed.row_end = o_row_end;
            observed.frame_end = o_frame_end;
            sb.check_result(observed);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_pixel(input logic signed [PIX_W-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(pix);
        burst_left--;
    endtask

    task automatic feed_random(input int unsigned count);
        int unsigned k;
        logic signed [PIX_W-1:0] pix;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0: pix = 16'sh7fff;
                1: pix = 16'sh8000;
                2: pix = 16'sh0000;
                3: pix = 16'shffff;
                default: pix = PIX_W'($urandom);
            endcase
            send_pixel(pix);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_reg idx, input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    task automatic configure(input bit do_w, input logic [CFG_W-1:0] w,
                             input bit do_h, input logic [CFG_W-1:0] h);
        if (do_w) write_cfg(REG_IMAGE_WIDTH, w);
        if (do_h) write_cfg(REG_IMAGE_HEIGHT, h);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned      sent_random;
        int unsigned      left;
        int unsigned      count;
        int unsigned      frame_px;
        bit               do_w;
        bit               do_h;
        int               pick;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;

        sent_random = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_IMAGE_WIDTH;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_pixel = '0;
        i_ready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset dimensions, then a shrink mid-row that forces the last column and row.
        send_pixel(16'sh7fff);
        send_pixel(16'sh8000);
        send_pixel(16'sh0001);
        send_pixel(16'shffff);
        send_pixel(16'sh1234);
        settle();
        configure(1'b1, 11'd4, 1'b1, 11'd0);
        send_pixel(16'sh8001);
        settle();

        // Odd width and height: full, vertical, horizontal and single blocks.
        configure(1'b1, 11'd3, 1'b1, 11'd3);
        send_pixel(16'sh7fff);
        send_pixel(16'sh7fff);
        send_pixel(16'sh8000);
        send_pixel(16'sh7fff);
        send_pixel(16'sh7fff);
        send_pixel(16'sh8000);
        send_pixel(16'sh8000);
        send_pixel(16'shffff);
        send_pixel(16'sh0001);
        settle();

        configure(1'b1, 11'd0, 1'b1, 11'd2);
        send_pixel(16'sh8000);
        send_pixel(16'sh7fff);
        settle();

        configure(1'b1, 11'd2047, 1'b1, 11'd1);
        send_pixel(16'sh0003);
        send_pixel(16'sh8000);
        send_pixel(16'shfffe);
        settle();
        configure(1'b1, 11'd2, 1'b0, '0);
        send_pixel(16'shffff);
        settle();

        while (sent_random < RANDOM_ITEMS) begin
            settle();
            pick = $urandom_range(0, 99);
            if (pick < 5) w = 11'd0;
            else if (pick < 10) w = 11'd1;
            else if (pick < 15) w = 11'd2;
            else if (pick < 18) w = 11'd1024;
            else if (pick < 21) w = CFG_W'($urandom_range(1025, 2047));
            else w = CFG_W'($urandom_range(3, 24));
            pick = $urandom_range(0, 99);
            if (pick < 5) h = 11'd0;
            else if (pick < 12) h = 11'd1;
            else if (pick < 20) h = 11'd2;
            else if (pick < 23) h = CFG_W'($urandom_range(1025, 2047));
            else h = CFG_W'($urandom_range(3, 8));
            do_w = ($urandom_range(0, 4) != 0) && sb.width_is_safe(w);
            do_h = ($urandom_range(0, 4) != 0);
            configure(do_w, w, do_h, h);
            left = sb.pixels_left_in_frame();
            frame_px = sb.clamp_dim(sb.width_reg, MAX_WIDTH)
                       * sb.clamp_dim(sb.height_reg, MAX_HEIGHT);
            if ($urandom_range(0, 3) != 0 && left <= 200) begin
                count = left;
                if (frame_px <= 60 && $urandom_range(0, 1)) count += frame_px;
            end else begin
                count = $urandom_range(1, 30);
            end
            feed_random(count);
            sent_random += count;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_means.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
